[src/prhd_pkg.sv]
// Shared constants, widths, register indexes and types of the PI ramp/hold regulator.
`timescale 1ns / 1ps

package prhd_pkg;

    localparam int PULSE_SAMPLES = 1024;
    localparam int SAMPLE_PERIOD = 1;

    localparam int IDX_W  = $clog2(PULSE_SAMPLES);
    localparam int HEND_W = $clog2(PULSE_SAMPLES + 1);

    localparam int MEAS_W = 16;
    localparam int SP_W   = 16;
    localparam int GAIN_W = 16;
    localparam int QI_W   = 15;
    localparam int DAC_W  = 12;
    localparam int UMAX_W = 15;
    localparam int TIME_W = 16;
    localparam int ERR_W  = 17;
    localparam int ODRV_W = 18;
    localparam int FRAC_W = 12;

    localparam int MUL_W  = 17;
    localparam int PROD_W = 2 * MUL_W;
    localparam int DIV_NW = UMAX_W + IDX_W;
    localparam int DIV_DW = TIME_W;
    localparam int ACC_W  = 34;
    localparam int INT_W  = QI_W + FRAC_W + 1;
    localparam int DRV_W  = ACC_W - FRAC_W;
    localparam int DV_W   = DRV_W + 1;
    localparam int HSUM_W = DIV_NW + 1;
    localparam int CIDX_W = 3;
    localparam int CDAT_W = 16;

    typedef enum logic [CIDX_W-1:0] {
        CFG_KP         = 3'd0,
        CFG_KI_TOTAL   = 3'd1,
        CFG_QI_MAX     = 3'd2,
        CFG_DAC_OFFSET = 3'd3,
        CFG_DAC_LIMIT  = 3'd4,
        CFG_U_MAX      = 3'd5,
        CFG_FRONT_TIME = 3'd6,
        CFG_HOLD_TIME  = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic signed [GAIN_W-1:0] kp;
        logic signed [GAIN_W-1:0] ki_total;
        logic [QI_W-1:0]          qi_max;
        logic [DAC_W-1:0]         dac_offset;
        logic [DAC_W-1:0]         dac_limit;
        logic [UMAX_W-1:0]        u_max;
        logic [TIME_W-1:0]        front_time;
        logic [TIME_W-1:0]        hold_time;
    } t_cfg;

endpackage

[src/prhd_cfg.sv]
// Configuration register file of the PI ramp/hold regulator.
`timescale 1ns / 1ps

module prhd_cfg
    import prhd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_en,
    input  logic [CIDX_W-1:0] i_index,
    input  logic [CDAT_W-1:0] i_data,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            unique case (t_cfg_idx'(i_index))
                CFG_KP:         n_cfg.kp         = i_data;
                CFG_KI_TOTAL:   n_cfg.ki_total   = i_data;
                CFG_QI_MAX:     n_cfg.qi_max     = i_data[QI_W-1:0];
                CFG_DAC_OFFSET: n_cfg.dac_offset = i_data[DAC_W-1:0];
                CFG_DAC_LIMIT:  n_cfg.dac_limit  = i_data[DAC_W-1:0];
                CFG_U_MAX:      n_cfg.u_max      = i_data[UMAX_W-1:0];
                CFG_FRONT_TIME: n_cfg.front_time = i_data[TIME_W-1:0];
                CFG_HOLD_TIME:  n_cfg.hold_time  = i_data[TIME_W-1:0];
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp         <= '0;
            r_cfg.ki_total   <= '0;
            r_cfg.qi_max     <= '0;
            r_cfg.dac_offset <= '0;
            r_cfg.dac_limit  <= '1;
            r_cfg.u_max      <= '0;
            r_cfg.front_time <= TIME_W'(1);
            r_cfg.hold_time  <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[src/prhd_mul.sv]
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps

module prhd_mul
    import prhd_pkg::*;
(
    input  logic                     i_clk,
    input  logic signed [MUL_W-1:0]  i_a,
    input  logic signed [MUL_W-1:0]  i_b,
    output logic signed [PROD_W-1:0] o_p
);

    logic signed [PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

[src/prhd_div.sv]
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module prhd_div
    import prhd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_NW-1:0] i_dividend,
    input  logic [DIV_DW-1:0] i_divisor,
    output logic              o_done,
    output logic [DIV_NW-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DIV_NW);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [DIV_DW-1:0] r_rem, n_rem;
    logic [DIV_NW-1:0] r_quo, n_quo;
    logic [DIV_DW-1:0] r_den, n_den;
    logic [DIV_DW:0]   rem_sh;
    logic [DIV_DW:0]   rem_diff;
    logic              fits;

    assign rem_sh   = {r_rem, r_quo[DIV_NW-1]};
    assign rem_diff = rem_sh - {1'b0, r_den};
    assign fits     = rem_sh >= {1'b0, r_den};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_dividend;
            n_den  = i_divisor;
        end else if (r_busy) begin
            n_rem = fits ? rem_diff[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
            n_quo = {r_quo[DIV_NW-2:0], fits};
            n_cnt = r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(DIV_NW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

[src/pi_regulator_ramp_hold_dac.sv]
// Top level of the PI voltage regulator with computed ramp/hold setpoint and DAC clamp.
`timescale 1ns / 1ps

// One item is taken at a time and o_in_ready stays low until it is finished. A regulate
// item is quickest when the setpoint comes from a hold or is zero, and slowest on the
// ramp front, where the 25-bit restoring divider that forms u_max*index/front_time
// produces one quotient bit per cycle. A hold item also takes longer on the ramp
// front, since its setpoint goes through the same divider. Every product goes through
// one shared 17x17 multiplier. A finished result waits in the output register while
// the next item is already being worked on.
module pi_regulator_ramp_hold_dac
    import prhd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CIDX_W-1:0]        i_cfg_index,
    input  logic [CDAT_W-1:0]        i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_action,
    input  logic [MEAS_W-1:0]        i_measured,
    input  logic                     i_bypass,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [DAC_W-1:0]         o_dac_code,
    output logic signed [ERR_W-1:0]  o_error_value,
    output logic signed [ODRV_W-1:0] o_drive_value,
    output logic                     o_pulse_done
);

    typedef enum logic [14:0] {
        S_IDLE   = 15'h0001,
        S_SP     = 15'h0002,
        S_RMUL   = 15'h0004,
        S_RDGO   = 15'h0008,
        S_RDWAIT = 15'h0010,
        S_HOLD   = 15'h0020,
        S_ERR    = 15'h0040,
        S_PMUL   = 15'h0080,
        S_PACC   = 15'h0100,
        S_IMUL   = 15'h0200,
        S_IADD   = 15'h0400,
        S_ICLAMP = 15'h0800,
        S_SUM    = 15'h1000,
        S_DRIVE  = 15'h2000,
        S_OUT    = 15'h4000
    } t_state;

    localparam logic signed [DRV_W-1:0] DRV_MAX = DRV_W'(2 ** (ODRV_W - 1) - 1);
    localparam logic signed [DRV_W-1:0] DRV_MIN = -DRV_W'(2 ** (ODRV_W - 1));

    t_cfg     cfg;
    logic     div_start;
    logic     div_done;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic [DIV_NW-1:0]        div_num, div_q;
    logic [DIV_DW-1:0]        div_den;

    t_state              r_state, n_state;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic signed [INT_W-1:0] r_int, n_int;
    logic                r_hold_active, n_hold_active;
    logic [SP_W-1:0]     r_held, n_held;
    logic [HEND_W-1:0]   r_hold_end, n_hold_end;
    logic                r_out_valid, n_out_valid;

    logic                r_action, n_action;
    logic [MEAS_W-1:0]   r_meas, n_meas;
    logic                r_bypass, n_bypass;
    logic [SP_W-1:0]     r_sp, n_sp;
    logic signed [ERR_W-1:0] r_err, n_err;
    logic signed [ACC_W-1:0] r_acc, n_acc;
    logic signed [ACC_W-1:0] r_iraw, n_iraw;
    logic signed [DRV_W-1:0] r_drive, n_drive;
    logic [DAC_W-1:0]    r_dac, n_dac;
    logic signed [ERR_W-1:0]  r_oerr, n_oerr;
    logic signed [ODRV_W-1:0] r_odrv, n_odrv;
    logic                r_odone, n_odone;

    logic                    on_front;
    logic [31:0]             front_need;
    logic signed [ACC_W-1:0] ilim, ilim_neg;
    logic [HSUM_W-1:0]       hsum;
    logic signed [DV_W-1:0]  dv_src, dv;
    logic                    last_sample;

    prhd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    prhd_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    prhd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_num),
        .i_divisor  (div_den),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);

    assign front_need  = (32'(r_idx) + 32'd1) * 32'(SAMPLE_PERIOD);
    assign on_front    = (front_need <= 32'(cfg.front_time));
    assign ilim        = ACC_W'($signed({1'b0, cfg.qi_max, {FRAC_W{1'b0}}}));
    assign ilim_neg    = -ilim;
    assign hsum        = HSUM_W'(r_idx) + HSUM_W'(cfg.hold_time / TIME_W'(SAMPLE_PERIOD));
    assign last_sample = (r_idx == IDX_W'(PULSE_SAMPLES - 1));

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_RMUL: begin
                mul_a = MUL_W'(cfg.u_max);
                mul_b = MUL_W'(r_idx);
            end
            S_PMUL: begin
                mul_a = MUL_W'(r_err);
                mul_b = MUL_W'(cfg.kp);
            end
            S_IMUL: begin
                mul_a = MUL_W'(r_err);
                mul_b = MUL_W'(cfg.ki_total);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign div_start = (r_state == S_RDGO);
    assign div_num   = mul_p[DIV_NW-1:0];
    assign div_den   = cfg.front_time;

    always_comb begin
        dv_src = r_bypass ? DV_W'($signed({1'b0, r_sp})) : DV_W'(r_drive);
        dv     = dv_src + DV_W'($signed({1'b0, cfg.dac_offset}));
    end

    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        n_int         = r_int;
        n_hold_active = r_hold_active;
        n_held        = r_held;
        n_hold_end    = r_hold_end;
        n_out_valid   = r_out_valid;
        n_action      = r_action;
        n_meas        = r_meas;
        n_bypass      = r_bypass;
        n_sp          = r_sp;
        n_err         = r_err;
        n_acc         = r_acc;
        n_iraw        = r_iraw;
        n_drive       = r_drive;
        n_dac         = r_dac;
        n_oerr        = r_oerr;
        n_odrv        = r_odrv;
        n_odone       = r_odone;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_action = i_action;
                    n_meas   = i_measured;
                    n_bypass = i_bypass;
                    n_state  = S_SP;
                end
            end
            S_SP: begin
                if (r_hold_active) begin
                    n_sp    = (HEND_W'(r_idx) < r_hold_end) ? r_held : '0;
                    n_state = r_action ? S_HOLD : S_ERR;
                end else if (on_front) begin
                    n_state = S_RMUL;
                end else begin
                    n_sp    = '0;
                    n_state = r_action ? S_HOLD : S_ERR;
                end
            end
            S_RMUL: begin
                n_state = S_RDGO;
            end
            S_RDGO: begin
                n_state = S_RDWAIT;
            end
            S_RDWAIT: begin
                if (div_done) begin
                    n_sp    = div_q[SP_W-1:0];
                    n_state = r_action ? S_HOLD : S_ERR;
                end
            end
            S_HOLD: begin
                n_held        = r_sp;
                n_hold_active = 1'b1;
                n_hold_end    = (hsum > HSUM_W'(PULSE_SAMPLES)) ?
                                HEND_W'(PULSE_SAMPLES) : hsum[HEND_W-1:0];
                n_state       = S_IDLE;
            end
            S_ERR: begin
                n_err   = (r_idx == '0) ? '0 :
                          ($signed({1'b0, r_sp}) - $signed({1'b0, r_meas}));
                n_state = S_PMUL;
            end
            S_PMUL: begin
                n_state = S_PACC;
            end
            S_PACC: begin
                n_acc   = ACC_W'($signed({1'b0, r_sp, {FRAC_W{1'b0}}})) + ACC_W'(mul_p);
                n_state = S_IMUL;
            end
            S_IMUL: begin
                n_state = S_IADD;
            end
            S_IADD: begin
                n_iraw  = ACC_W'(r_int) + ACC_W'(mul_p);
                n_state = S_ICLAMP;
            end
            S_ICLAMP: begin
                if (r_iraw > ilim) begin
                    n_int = ilim[INT_W-1:0];
                end else if (r_iraw < ilim_neg) begin
                    n_int = ilim_neg[INT_W-1:0];
                end else begin
                    n_int = r_iraw[INT_W-1:0];
                end
                n_state = S_SUM;
            end
            S_SUM: begin
                n_acc   = r_acc + ACC_W'(r_int);
                n_state = S_DRIVE;
            end
            S_DRIVE: begin
                n_drive = r_acc[ACC_W-1:FRAC_W] +
                          DRV_W'(r_acc[ACC_W-1] && (r_acc[FRAC_W-1:0] != '0));
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    if (dv < 0) begin
                        n_dac = '0;
                    end else if (dv > DV_W'($signed({1'b0, cfg.dac_limit}))) begin
                        n_dac = cfg.dac_limit;
                    end else begin
                        n_dac = dv[DAC_W-1:0];
                    end
                    if (r_drive > DRV_MAX) begin
                        n_odrv = DRV_MAX[ODRV_W-1:0];
                    end else if (r_drive < DRV_MIN) begin
                        n_odrv = DRV_MIN[ODRV_W-1:0];
                    end else begin
                        n_odrv = r_drive[ODRV_W-1:0];
                    end
                    n_oerr      = r_err;
                    n_odone     = last_sample;
                    n_out_valid = 1'b1;
                    if (last_sample) begin
                        n_idx         = '0;
                        n_int         = '0;
                        n_hold_active = 1'b0;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_idx         <= '0;
            r_int         <= '0;
            r_hold_active <= 1'b0;
            r_held        <= '0;
            r_hold_end    <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_idx         <= n_idx;
            r_int         <= n_int;
            r_hold_active <= n_hold_active;
            r_held        <= n_held;
            r_hold_end    <= n_hold_end;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action <= n_action;
        r_meas   <= n_meas;
        r_bypass <= n_bypass;
        r_sp     <= n_sp;
        r_err    <= n_err;
        r_acc    <= n_acc;
        r_iraw   <= n_iraw;
        r_drive  <= n_drive;
        r_dac    <= n_dac;
        r_oerr   <= n_oerr;
        r_odrv   <= n_odrv;
        r_odone  <= n_odone;
    end

    assign o_out_valid   = r_out_valid;
    assign o_dac_code    = r_dac;
    assign o_error_value = r_oerr;
    assign o_drive_value = r_odrv;
    assign o_pulse_done  = r_odone;

`ifndef SYNTH
    a_int_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUM) |-> ((ACC_W'(r_int) <= ilim) && (ACC_W'(r_int) >= ilim_neg)))
        else $error("Integral left its clamp range.");

    a_hold_end_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold_end <= HEND_W'(PULSE_SAMPLES))
        else $error("Hold end beyond the pulse length.");

    a_div_only_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_RDWAIT))
        else $error("Divider finished outside a wait state.");

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_SP))
        else $error("Accepted item did not start the setpoint step.");
`endif

endmodule
